>>> hdl/mbtp_pkg.sv
// Shared constants, types and helper functions for the moving bar test pattern.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps

package mbtp_pkg;

  // Sizing
  localparam int NUMBER_BITS = 16;    // frame number bits shown in the top band, power of two
  localparam int MAX_DIM     = 4096;  // largest frame width or height

  // Fixed field widths
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int KIND_W      = 2;
  localparam int COL_W       = 12;
  localparam int LINE_W      = 12;
  localparam int FRAME_W     = 32;
  localparam int SAMPLE_W    = 8;

  // Derived widths
  localparam int POS_W       = $clog2(MAX_DIM);
  localparam int DIM_W       = POS_W + 1;
  localparam int EXT_W       = (CFG_W > DIM_W) ? CFG_W : DIM_W;
  localparam int CMP_A       = (LINE_W + 1 > COL_W) ? LINE_W + 1 : COL_W;
  localparam int CMP_W       = (CMP_A > DIM_W) ? CMP_A : DIM_W;
  localparam int NB_LOG2     = $clog2(NUMBER_BITS);
  localparam int BLK_W       = (NB_LOG2 > 0) ? NB_LOG2 : 1;

  // Pattern geometry
  localparam int PPF_LOG2    = 2;   // bars move 4 pixels per frame
  localparam int BAR_LOG2    = 3;   // 8 bars
  localparam int BAND_LOG2   = 3;   // number band is the top eighth
  localparam int MIN_DIM     = 64;
  localparam int MAX_EVEN    = (MAX_DIM / 2) * 2;

  // Remainder pipeline: (4*n + column) mod width, then 3 quotient bits of 8*pos/width
  localparam int D_W         = FRAME_W + PPF_LOG2 + 1;
  localparam int DIV_STEPS   = D_W + BAR_LOG2;
  localparam int SPS         = 7;   // restoring steps per stage
  localparam int MOD_STAGES  = (DIV_STEPS + SPS - 1) / SPS;
  localparam int PIPE_DEPTH  = MOD_STAGES + 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // Plane codes
  localparam logic [KIND_W-1:0] KIND_LUMA = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CB   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CR   = 2'd2;

  // Levels
  localparam logic [SAMPLE_W-1:0] WHITE_LEVEL    = 8'd235;
  localparam logic [SAMPLE_W-1:0] BLACK_LEVEL    = 8'd16;
  localparam logic [SAMPLE_W-1:0] NEUTRAL_CHROMA = 8'd128;
  localparam logic [SAMPLE_W-1:0] NO_SAMPLE      = 8'd0;

  localparam logic [SAMPLE_W-1:0] BAR_Y  [8] = '{8'd180, 8'd168, 8'd145, 8'd133,
                                                 8'd63,  8'd51,  8'd28,  8'd16};
  localparam logic [SAMPLE_W-1:0] BAR_CB [8] = '{8'd128, 8'd44,  8'd147, 8'd63,
                                                 8'd193, 8'd109, 8'd212, 8'd128};
  localparam logic [SAMPLE_W-1:0] BAR_CR [8] = '{8'd128, 8'd136, 8'd44,  8'd52,
                                                 8'd204, 8'd212, 8'd120, 8'd128};

  // Side data that rides along the remainder pipeline
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic                use_level;
    logic [SAMPLE_W-1:0] level;
  } mbtp_side_t;

  // Clear the low bit, then clamp to [64, MAX_DIM rounded down to even]
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v) & ~EXT_W'(1);
    if (e > EXT_W'(MAX_EVEN)) e = EXT_W'(MAX_EVEN);
    if (e < EXT_W'(MIN_DIM)) e = EXT_W'(MIN_DIM);
    return DIM_W'(e);
  endfunction

  function automatic logic [SAMPLE_W-1:0] bar_sample(input logic [BAR_LOG2-1:0] idx,
                                                     input logic [KIND_W-1:0] kind);
    logic [SAMPLE_W-1:0] s;
    case (kind)
      KIND_LUMA: s = BAR_Y[idx];
      KIND_CB:   s = BAR_CB[idx];
      KIND_CR:   s = BAR_CR[idx];
      default:   s = NO_SAMPLE;
    endcase
    return s;
  endfunction

endpackage

>>> hdl/mbtp_bar_div.sv
// Pipelined restoring remainder unit: bar position modulo frame width, then bar index.
// Depends on mbtp_pkg.
`timescale 1ns / 1ps

module mbtp_bar_div
  import mbtp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [D_W-1:0]      dividend,
  input  mbtp_side_t          side_in,
  input  logic [DIM_W-1:0]    width,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [BAR_LOG2-1:0] bar_idx,
  output mbtp_side_t          side_out
);

  logic [MOD_STAGES-1:0] valid;
  logic [MOD_STAGES-1:0] en;

  logic [POS_W-1:0]    rem      [MOD_STAGES];
  logic [D_W-1:0]      dvd      [MOD_STAGES];
  logic [BAR_LOG2-1:0] idx      [MOD_STAGES];
  mbtp_side_t          side     [MOD_STAGES];

  logic [POS_W-1:0]    rem_in   [MOD_STAGES];
  logic [D_W-1:0]      dvd_in   [MOD_STAGES];
  logic [BAR_LOG2-1:0] idx_in   [MOD_STAGES];
  mbtp_side_t          side_in_s[MOD_STAGES];

  logic [POS_W-1:0]    rem_next [MOD_STAGES];
  logic [D_W-1:0]      dvd_next [MOD_STAGES];
  logic [BAR_LOG2-1:0] idx_next [MOD_STAGES];

  // A stage loads when it is empty or its content moves on
  always_comb begin
    en[MOD_STAGES-1] = !valid[MOD_STAGES-1] || out_ready;
    for (int k = MOD_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_comb begin
    rem_in[0]    = '0;
    dvd_in[0]    = dividend;
    idx_in[0]    = '0;
    side_in_s[0] = side_in;
    for (int g = 1; g < MOD_STAGES; g++) begin
      rem_in[g]    = rem[g-1];
      dvd_in[g]    = dvd[g-1];
      idx_in[g]    = idx[g-1];
      side_in_s[g] = side[g-1];
    end
  end

  // SPS restoring steps per stage; dividend bits first, then quotient bits of 8*pos/width
  always_comb begin
    logic [POS_W:0]      t;
    logic                ge;
    logic [POS_W-1:0]    r;
    logic [D_W-1:0]      d;
    logic [BAR_LOG2-1:0] q;
    t  = '0;
    ge = 1'b0;
    for (int g = 0; g < MOD_STAGES; g++) begin
      r = rem_in[g];
      d = dvd_in[g];
      q = idx_in[g];
      for (int j = 0; j < SPS; j++) begin
        if (g * SPS + j < DIV_STEPS) begin
          t  = {r, d[D_W-1]};
          d  = d << 1;
          ge = (t >= width);
          r  = ge ? POS_W'(t - width) : POS_W'(t);
          if (g * SPS + j >= D_W) q = BAR_LOG2'({q, ge});
        end
      end
      rem_next[g] = r;
      dvd_next[g] = d;
      idx_next[g] = q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) valid[0] <= in_valid;
      for (int k = 1; k < MOD_STAGES; k++) begin
        if (en[k]) valid[k] <= valid[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MOD_STAGES; k++) begin
      if (en[k]) begin
        rem[k]  <= rem_next[k];
        dvd[k]  <= dvd_next[k];
        idx[k]  <= idx_next[k];
        side[k] <= side_in_s[k];
      end
    end
  end

  assign out_valid = valid[MOD_STAGES-1];
  assign bar_idx   = idx[MOD_STAGES-1];
  assign side_out  = side[MOD_STAGES-1];

endmodule

>>> hdl/moving_bar_test_pattern.sv
// Top level of the moving bar test pattern: request capture, top-band logic, output register.
// Depends on mbtp_pkg and mbtp_bar_div.
//
//   channel   direction  handshake                   payload
//   pixel     in         pixel_valid / pixel_ready   kind, col, line, frame_number
//   sample    out        sample_valid / sample_ready sample
//   cfg       in         cfg_write (no wait)         cfg_index, cfg_data
//
// One request enters per clock when nothing stalls. The pipeline depth, PIPE_DEPTH, is set
// by the remainder pipeline: 38 restoring steps, seven per stage, over six stages, plus
// the request register and the output register.
// Reset clears all valid bits and loads frame_width 1280, frame_height 720.
// A stall at the output fills bubbles first, then holds every stage in place.
`timescale 1ns / 1ps

module moving_bar_test_pattern
  import mbtp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // requests
  input  logic                 pixel_valid,
  output logic                 pixel_ready,
  input  logic [KIND_W-1:0]    kind,
  input  logic [COL_W-1:0]     col,
  input  logic [LINE_W-1:0]    line,
  input  logic [FRAME_W-1:0]   frame_number,
  // results
  output logic                 sample_valid,
  input  logic                 sample_ready,
  output logic [SAMPLE_W-1:0]  sample
);

  localparam logic [DIM_W-1:0] W_RESET    = eff_dim(CFG_W'(1280));
  localparam logic [DIM_W-1:0] BW_RESET   = W_RESET >> NB_LOG2;
  localparam logic [DIM_W-1:0] BAND_RESET = eff_dim(CFG_W'(720)) >> BAND_LOG2;
  localparam logic [BLK_W-1:0] NB_TOP     = BLK_W'(NUMBER_BITS - 1);

  // Effective sizes, stored already clamped so the datapath never sees raw values
  logic [DIM_W-1:0] width;       // bar wrap width
  logic [DIM_W-1:0] blk_width;   // width of one number block
  logic [DIM_W-1:0] band;        // number band height in luma lines

  always_ff @(posedge clk) begin
    if (rst) begin
      width     <= W_RESET;
      blk_width <= BW_RESET;
      band      <= BAND_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          width     <= eff_dim(cfg_data);
          blk_width <= eff_dim(cfg_data) >> NB_LOG2;
        end
        REG_FRAME_HEIGHT: begin
          band <= eff_dim(cfg_data) >> BAND_LOG2;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: request register
  // ---------------------------------------------------------------------------
  logic               req_valid;
  logic [KIND_W-1:0]  req_kind;
  logic [COL_W-1:0]   req_col;
  logic [LINE_W-1:0]  req_line;
  logic [FRAME_W-1:0] req_frame;
  logic               req_en;
  logic               div_in_ready;

  // Take a new request whenever the register is empty or hands its request on
  assign req_en      = !req_valid || div_in_ready;
  assign pixel_ready = req_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_en) begin
      req_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_en && pixel_valid) begin
      req_kind  <= kind;
      req_col   <= col;
      req_line  <= line;
      req_frame <= frame_number;
    end
  end

  // ---------------------------------------------------------------------------
  // Work on the registered request: dividend for the bar position, band test,
  // and the frame number block that a luma pixel in the band falls into.
  // ---------------------------------------------------------------------------
  logic                   is_luma;
  logic                   is_chroma;
  logic [D_W-1:0]         dividend;
  logic [CMP_W-1:0]       luma_line;
  logic                   in_band;
  logic [CMP_W-1:0]       blk_rem;
  logic [CMP_W-1:0]       blk_step;
  logic [BLK_W-1:0]       blk;
  logic                   blk_in_range;
  logic [NUMBER_BITS-1:0] shown_bits;
  logic [SAMPLE_W-1:0]    luma_level;
  mbtp_side_t             side_req;

  assign is_luma   = (req_kind == KIND_LUMA);
  assign is_chroma = (req_kind == KIND_CB) || (req_kind == KIND_CR);

  // Chroma columns map to luma column 2*col; the shift 4*n is folded into one dividend
  assign dividend = (D_W'(req_frame) << PPF_LOG2) +
                    (is_luma ? D_W'(req_col) : D_W'({req_col, 1'b0}));

  assign luma_line = is_luma ? CMP_W'(req_line) : CMP_W'({req_line, 1'b0});
  assign in_band   = luma_line < CMP_W'(band);

  // Block index: a short restoring divide of the column by the block width
  assign blk_in_range = CMP_W'(req_col) < (CMP_W'(blk_width) << NB_LOG2);

  always_comb begin
    blk_rem  = CMP_W'(req_col);
    blk_step = '0;
    blk      = '0;
    for (int k = NB_LOG2 - 1; k >= 0; k--) begin
      blk_step = CMP_W'(blk_width) << k;
      if (blk_rem >= blk_step) begin
        blk_rem = blk_rem - blk_step;
        blk     = BLK_W'({blk, 1'b1});
      end else begin
        blk     = BLK_W'({blk, 1'b0});
      end
    end
  end

  // Most significant bit goes in the leftmost block; past the last block is black
  assign shown_bits = req_frame[NUMBER_BITS-1:0];
  assign luma_level = (blk_in_range && shown_bits[NB_TOP - blk]) ? WHITE_LEVEL : BLACK_LEVEL;

  always_comb begin
    side_req.kind = req_kind;
    if (is_luma) begin
      side_req.use_level = in_band;
      side_req.level     = luma_level;
    end else if (is_chroma) begin
      side_req.use_level = in_band;
      side_req.level     = NEUTRAL_CHROMA;
    end else begin
      // unused plane code: a fixed zero sample
      side_req.use_level = 1'b1;
      side_req.level     = NO_SAMPLE;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 2..7: bar position modulo width and bar index
  // ---------------------------------------------------------------------------
  logic                div_valid;
  logic                div_ready;
  logic [BAR_LOG2-1:0] bar_idx;
  mbtp_side_t          side_div;

  mbtp_bar_div u_bar_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_valid),
    .in_ready  (div_in_ready),
    .dividend  (dividend),
    .side_in   (side_req),
    .width     (width),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .bar_idx   (bar_idx),
    .side_out  (side_div)
  );

  // ---------------------------------------------------------------------------
  // Stage 8: color lookup into the output register
  // ---------------------------------------------------------------------------
  logic                out_en;
  logic [SAMPLE_W-1:0] sample_next;

  // Load when empty or when the held sample is taken this cycle
  assign out_en    = !sample_valid || sample_ready;
  assign div_ready = out_en;

  assign sample_next = side_div.use_level ? side_div.level : bar_sample(bar_idx, side_div.kind);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (out_en) begin
      sample_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && div_valid) begin
      sample <= sample_next;
    end
  end

endmodule

>>> hdl/mbtp_checker.sv
// Port-level checks for moving_bar_test_pattern, attached by the bind at the end.
// Depends on mbtp_pkg.
`timescale 1ns / 1ps

module mbtp_checker
  import mbtp_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                pixel_valid,
  input logic                pixel_ready,
  input logic                sample_valid,
  input logic                sample_ready,
  input logic [SAMPLE_W-1:0] sample
);

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

  logic [CNT_W-1:0] inflight;
  logic             take_in;
  logic             take_out;

  assign take_in  = pixel_valid && pixel_ready;
  assign take_out = sample_valid && sample_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CNT_W'(take_in) - CNT_W'(take_out);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !sample_valid)
    else $error("sample_valid high after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_ready |=> sample_valid && $stable(sample))
    else $error("stalled sample changed or dropped");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    sample_valid |-> inflight != '0)
    else $error("sample without an outstanding request");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    take_in |-> inflight < CNT_W'(PIPE_DEPTH) || take_out)
    else $error("more requests in flight than pipeline stages");

  a_level: assert property (@(posedge clk) disable iff (rst)
    sample_valid |-> sample == 8'd0 || sample == 8'd16 || sample == 8'd235 ||
                     sample == 8'd128 || sample == 8'd180 || sample == 8'd168 ||
                     sample == 8'd145 || sample == 8'd133 || sample == 8'd63 ||
                     sample == 8'd51 || sample == 8'd28 || sample == 8'd44 ||
                     sample == 8'd136 || sample == 8'd147 || sample == 8'd52 ||
                     sample == 8'd193 || sample == 8'd204 || sample == 8'd109 ||
                     sample == 8'd212 || sample == 8'd120)
    else $error("sample is not a pattern level");

endmodule

bind moving_bar_test_pattern mbtp_checker u_mbtp_checker (.*);

>>> verif/moving_bar_test_pattern_test.sv
// Self-checking testbench for moving_bar_test_pattern: directed rows, then random requests.
// Depends on mbtp_pkg (widths, plane and register codes) and the moving_bar_test_pattern RTL.
`timescale 1ns / 1ps

module moving_bar_test_pattern_test;
  import mbtp_pkg::*;

  // Bench timing and run shape
  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 9;
  localparam int PHASES          = 10;
  localparam int RANDOM_PHASE    = 7;     // this phase draws both sizes at random
  localparam int ITEMS_PER_PHASE = 75;
  localparam int HOLD_CYCLES     = 300;   // long output back-pressure stretch
  localparam int WATCHDOG_LIMIT  = 4000;  // cycles with no handshake before giving up
  localparam int REPORT_LIMIT    = 10;

  // Plane code that selects nothing
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Expected levels, kept apart from the package so the bench does not echo the RTL
  localparam logic [SAMPLE_W-1:0] LEVEL_ONE_BIT     = 8'd235;
  localparam logic [SAMPLE_W-1:0] LEVEL_ZERO_BIT    = 8'd16;
  localparam logic [SAMPLE_W-1:0] LEVEL_CHROMA_FLAT = 8'd128;
  localparam logic [SAMPLE_W-1:0] LEVEL_NONE        = 8'd0;
  localparam int                  BAR_COUNT         = 8;
  localparam int                  SHIFT_PER_FRAME   = 4;
  localparam int                  SMALLEST_DIM      = 64;
  localparam int                  LARGEST_DIM       = 4096;

  // 75% bars, left to right; columns are Y, Cb, Cr (indexed by the plane code)
  localparam logic [SAMPLE_W-1:0] BAR_LEVELS [BAR_COUNT][3] = '{
    '{8'd180, 8'd128, 8'd128}, '{8'd168, 8'd44,  8'd136},
    '{8'd145, 8'd147, 8'd44},  '{8'd133, 8'd63,  8'd52},
    '{8'd63,  8'd193, 8'd204}, '{8'd51,  8'd109, 8'd212},
    '{8'd28,  8'd212, 8'd120}, '{8'd16,  8'd128, 8'd128}
  };

  // One directed request; level is typed in only where known is set
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [COL_W-1:0]    col;
    logic [LINE_W-1:0]   line;
    logic [FRAME_W-1:0]  frame_number;
    bit                  known;
    logic [SAMPLE_W-1:0] level;
  } pixel_row_t;

  // Rows assume the reset sizes: 1280 x 720, so the number band is 90 lines and
  // each number block is 80 pixels wide.
  localparam int DIRECTED_ROWS = 23;
  pixel_row_t directed_rows [DIRECTED_ROWS] = '{
    // number band: MSB block, LSB block, past the last block, far off the plane
    '{KIND_LUMA,   12'd0,    12'd0,    32'h0000_0000, 1'b1, 8'd16},
    '{KIND_LUMA,   12'd0,    12'd0,    32'h0000_8000, 1'b1, 8'd235},
    '{KIND_LUMA,   12'd1279, 12'd89,   32'h0000_0001, 1'b1, 8'd235},
    '{KIND_LUMA,   12'd1280, 12'd0,    32'hFFFF_FFFF, 1'b1, 8'd16},
    '{KIND_LUMA,   12'd4095, 12'd0,    32'hFFFF_FFFF, 1'b1, 8'd16},
    // luma bars: first line under the band, last pixel, second bar
    '{KIND_LUMA,   12'd0,    12'd90,   32'h0000_0000, 1'b1, 8'd180},
    '{KIND_LUMA,   12'd1279, 12'd719,  32'h0000_0000, 1'b1, 8'd16},
    '{KIND_LUMA,   12'd160,  12'd100,  32'h0000_0000, 1'b1, 8'd168},
    // line beyond the height, col beyond the width, shifted bars
    '{KIND_LUMA,   12'd0,    12'd4095, 32'hFFFF_FFFF, 1'b0, 8'd0},
    '{KIND_LUMA,   12'd4095, 12'd4095, 32'h1234_5678, 1'b0, 8'd0},
    '{KIND_LUMA,   12'd0,    12'd200,  32'h0000_0001, 1'b0, 8'd0},
    '{KIND_LUMA,   12'd0,    12'd200,  32'd300,       1'b0, 8'd0},
    // chroma: flat inside the band, bars from luma column 2*col below it
    '{KIND_CB,     12'd0,    12'd0,    32'h0000_0000, 1'b1, 8'd128},
    '{KIND_CR,     12'd0,    12'd44,   32'h0000_0000, 1'b1, 8'd128},
    '{KIND_CB,     12'd80,   12'd45,   32'h0000_0000, 1'b1, 8'd44},
    '{KIND_CR,     12'd80,   12'd45,   32'h0000_0000, 1'b1, 8'd136},
    '{KIND_CB,     12'd320,  12'd359,  32'h0000_0000, 1'b1, 8'd193},
    '{KIND_CR,     12'd320,  12'd359,  32'h0000_0000, 1'b1, 8'd204},
    '{KIND_CB,     12'd4095, 12'd4095, 32'hFFFF_FFFF, 1'b0, 8'd0},
    '{KIND_CR,     12'd2048, 12'd2048, 32'hAAAA_5555, 1'b0, 8'd0},
    // unused plane selector always reads zero; then one predicted chroma row
    '{KIND_UNUSED, 12'd0,    12'd0,    32'h0000_0000, 1'b1, 8'd0},
    '{KIND_UNUSED, 12'd4095, 12'd4095, 32'hFFFF_FFFF, 1'b1, 8'd0},
    '{KIND_CB,     12'd10,   12'd300,  32'd12345,     1'b0, 8'd0}
  };

  // Per-phase sizes and idling; odd, tiny and oversized values exercise the clamp
  logic [CFG_W-1:0] phase_width  [PHASES] = '{13'd1280, 13'd64,   13'd4096, 13'd8191, 13'd0,
                                              13'd65,   13'd1920, 13'd0,    13'd640,  13'd4094};
  logic [CFG_W-1:0] phase_height [PHASES] = '{13'd720,  13'd64,   13'd4096, 13'd8191, 13'd1,
                                              13'd99,   13'd1080, 13'd0,    13'd480,  13'd66};
  int               phase_send_idle [PHASES] = '{0, 88, 0,  7, 0, 88, 0,  7, 0, 7};
  int               phase_recv_stall[PHASES] = '{0, 0,  88, 7, 0, 0,  88, 7, 0, 7};
  bit               phase_hold_off  [PHASES] = '{0, 0,  0,  0, 1, 0,  0,  0, 0, 0};

  // DUT ports; every input starts at a known value
  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_data     = '0;
  logic                 pixel_valid  = 1'b0;
  logic                 pixel_ready;
  logic [KIND_W-1:0]    kind         = '0;
  logic [COL_W-1:0]     col          = '0;
  logic [LINE_W-1:0]    line         = '0;
  logic [FRAME_W-1:0]   frame_number = '0;
  logic                 sample_valid;
  logic                 sample_ready = 1'b0;
  logic [SAMPLE_W-1:0]  sample;

  // Bench copy of the size registers, as last written
  logic [CFG_W-1:0]     width_setting  = 13'd1280;
  logic [CFG_W-1:0]     height_setting = 13'd720;

  // Samples still owed by the block, oldest first
  logic [SAMPLE_W-1:0]  pending_samples [$];
  logic [SAMPLE_W-1:0]  owed_sample;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_request   = 1'b0;
  int hold_left      = 0;
  int fail_count     = 0;
  int quiet_cycles   = 0;

  moving_bar_test_pattern DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .kind         (kind),
    .col          (col),
    .line         (line),
    .frame_number (frame_number),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Effective size: drop the low bit, then clamp into the supported range.
  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
    int unsigned d;
    d = {v[CFG_W-1:1], 1'b0};
    if (d > LARGEST_DIM) d = LARGEST_DIM;
    if (d < SMALLEST_DIM) d = SMALLEST_DIM;
    return d;
  endfunction

  // Sample the block should return for one request under the current sizes.
  function automatic logic [SAMPLE_W-1:0] predict_sample(input logic [KIND_W-1:0]  k,
                                                         input logic [COL_W-1:0]   c,
                                                         input logic [LINE_W-1:0]  l,
                                                         input logic [FRAME_W-1:0] f);
    int unsigned         w, h, band, shift, block_w, block, bar, pos, row;
    longint unsigned     travel;
    logic [SAMPLE_W-1:0] level;
    w      = clamp_dim(width_setting);
    h      = clamp_dim(height_setting);
    band   = h / 8;
    // bars travel 4 pixels per frame; reduce in 64 bits so the product cannot wrap
    travel = 64'(f) * SHIFT_PER_FRAME;
    shift  = 32'(travel % 64'(w));
    pos    = 32'(c);
    row    = 32'(l);
    level  = LEVEL_NONE;
    if (k == KIND_LUMA) begin
      if (row < band) begin
        // frame number band: MSB leftmost, pixels past the last whole block stay black
        block_w = w / NUMBER_BITS;
        block   = pos / block_w;
        level   = LEVEL_ZERO_BIT;
        if (block < NUMBER_BITS) begin
          if (f[NUMBER_BITS - 1 - block]) level = LEVEL_ONE_BIT;
        end
      end else begin
        bar   = (((pos + shift) % w) * BAR_COUNT) / w;
        level = BAR_LEVELS[bar][0];
      end
    end else if (k == KIND_CB || k == KIND_CR) begin
      if (row * 2 < band) begin
        level = LEVEL_CHROMA_FLAT;
      end else begin
        // chroma takes the bar under luma column 2*col
        bar   = (((pos * 2 + shift) % w) * BAR_COUNT) / w;
        level = BAR_LEVELS[bar][k];
      end
    end
    return level;
  endfunction

  // Write one size register; call at a falling edge, returns at the next one.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == REG_FRAME_WIDTH) width_setting = value;
    else height_setting = value;
  endtask

  // Offer one request and hold it until accepted; record what it must produce.
  task automatic issue_pixel(input logic [KIND_W-1:0]   k,
                             input logic [COL_W-1:0]    c,
                             input logic [LINE_W-1:0]   l,
                             input logic [FRAME_W-1:0]  f,
                             input bit                  known,
                             input logic [SAMPLE_W-1:0] level);
    // random sender gaps land between requests, never inside one
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid = 1'b0;
      @(negedge clk);
    end
    pixel_valid  = 1'b1;
    kind         = k;
    col          = c;
    line         = l;
    frame_number = f;
    do @(posedge clk); while (!pixel_ready);
    pending_samples.push_back(known ? level : predict_sample(k, c, l, f));
    @(negedge clk);
  endtask

  // Draw one random request, weighted toward the interesting parts of the plane.
  task automatic issue_random_pixel();
    logic [KIND_W-1:0]  k;
    logic [COL_W-1:0]   c;
    logic [LINE_W-1:0]  l;
    logic [FRAME_W-1:0] f;
    int unsigned        plane_w, plane_h, plane_band, pick;
    pick = $urandom_range(15);
    if (pick == 0) k = KIND_UNUSED;
    else if (pick < 8) k = KIND_LUMA;
    else if (pick < 12) k = KIND_CB;
    else k = KIND_CR;
    plane_w    = clamp_dim(width_setting);
    plane_h    = clamp_dim(height_setting);
    plane_band = plane_h / 8;
    if (k != KIND_LUMA) begin
      plane_w    = plane_w / 2;
      plane_h    = plane_h / 2;
      plane_band = (plane_band + 1) / 2;
    end
    // columns: mostly on the plane, sometimes anywhere the field reaches
    if ($urandom_range(9) == 0) c = COL_W'($urandom_range(4095));
    else c = COL_W'($urandom_range(plane_w - 1));
    // lines: the number band and its lower edge get extra weight
    pick = $urandom_range(9);
    if (pick == 0) l = LINE_W'($urandom_range(4095));
    else if (pick < 4) l = LINE_W'($urandom_range(plane_band - 1));
    else if (pick == 4) l = LINE_W'(plane_band - 1 + $urandom_range(2));
    else l = LINE_W'($urandom_range(plane_h - 1));
    // frame numbers: near zero, near the wrap, low half only, or anything
    pick = $urandom_range(7);
    if (pick == 0) f = FRAME_W'($urandom_range(15));
    else if (pick == 1) f = 32'hFFFF_FFFF - FRAME_W'($urandom_range(15));
    else if (pick < 4) f = FRAME_W'($urandom_range(65535));
    else f = $urandom();
    issue_pixel(k, c, l, f, 1'b0, LEVEL_NONE);
  endtask

  // Stop offering, wait for every owed sample, then let the pipeline settle.
  task automatic drain_pipeline();
    pixel_valid = 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  // Output side: random stalls, plus one long hold-off on request so the
  // pipeline fills and pixel_ready drops while requests keep coming.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      sample_ready = 1'b0;
      hold_left    = hold_left - 1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES - 1;
      sample_ready = 1'b0;
    end else begin
      sample_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each returned sample with the oldest one owed.
  always @(posedge clk) begin
    if (!rst && sample_valid && sample_ready) begin
      if (pending_samples.size() == 0) begin
        fail_count = fail_count + 1;
        if (fail_count <= REPORT_LIMIT)
          $display("%0t: sample %0d returned with no request outstanding", $realtime, sample);
      end else begin
        owed_sample = pending_samples.pop_front();
        if (sample !== owed_sample) begin
          fail_count = fail_count + 1;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: sample mismatch: expected %0d, got %0d",
                     $realtime, owed_sample, sample);
        end
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if (rst || (pixel_valid && pixel_ready) || (sample_valid && sample_ready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("[moving_bar_test_pattern] ERROR");
      $finish;
    end
  end

  initial begin
    logic [CFG_W-1:0] next_width;
    logic [CFG_W-1:0] next_height;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    // Directed rows run at the reset sizes with no idling on either side.
    foreach (directed_rows[i])
      issue_pixel(directed_rows[i].kind, directed_rows[i].col, directed_rows[i].line,
                  directed_rows[i].frame_number, directed_rows[i].known,
                  directed_rows[i].level);

    // Random phases: resize only once the block has gone quiet, then switch idling.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_pipeline();
      next_width  = phase_width[phase];
      next_height = phase_height[phase];
      if (phase == RANDOM_PHASE) begin
        next_width  = CFG_W'($urandom_range(8191));
        next_height = CFG_W'($urandom_range(8191));
      end
      write_register(REG_FRAME_WIDTH, next_width);
      write_register(REG_FRAME_HEIGHT, next_height);
      send_idle_pct  = phase_send_idle[phase];
      recv_stall_pct = phase_recv_stall[phase];
      if (phase_hold_off[phase]) hold_request = 1'b1;
      repeat (ITEMS_PER_PHASE) issue_random_pixel();
    end

    // Let every owed sample come back, then give stray outputs a chance to show.
    drain_pipeline();
    if (fail_count == 0)
      $display("[moving_bar_test_pattern] OK");
    else
      $display("[moving_bar_test_pattern] ERROR");
    $finish;
  end

endmodule
